FILE: sv/skts_pkg.sv
// ----------------------------------------------------------------------------
// skts_pkg
// Shared codes, widths and controller/datapath interface types for the
// sorted key table search block.
// ----------------------------------------------------------------------------
package skts_pkg;

  localparam int KEY_W    = 64;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int INDEX_W  = 10;
  localparam int OUT_W    = 16;

  localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic accept;     // word taken: latch key, reset result, seed search
    logic op_load;
    logic op_clear;
    logic op_search;
    logic step;       // one search probe
    logic out_push;   // result into output register
  } skts_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic hit;
    logic empty;
  } skts_sts_t;

endpackage

FILE: sv/skts_ctrl.sv
// ----------------------------------------------------------------------------
// skts_ctrl
// Controller: sequences accept, search probes and result hand-off.
// ----------------------------------------------------------------------------
module skts_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [skts_pkg::KIND_W-1:0] kind,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  input  skts_pkg::skts_sts_t         sts,
  output skts_pkg::skts_cmd_t         cmd
);
  import skts_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    SRCH,
    FINISH
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == IDLE);

  always_comb begin
    cmd           = '0;
    cmd.accept    = (state == IDLE) && s_tvalid;
    cmd.op_load   = cmd.accept && (kind == KIND_LOAD);
    cmd.op_clear  = cmd.accept && (kind == KIND_CLEAR);
    cmd.op_search = cmd.accept && (kind == KIND_SEARCH);
    cmd.step      = (state == SRCH);
    cmd.out_push  = (state == FINISH) && (!m_tvalid || m_tready);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      IDLE: begin
        if (cmd.accept) begin
          state_next = (cmd.op_search && !sts.cnt_zero) ? SRCH : FINISH;
        end
      end
      SRCH: begin
        if (sts.hit || sts.empty) begin
          state_next = FINISH;
        end
      end
      FINISH: begin
        if (cmd.out_push) begin
          state_next = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_push) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

FILE: sv/skts_dp.sv
// ----------------------------------------------------------------------------
// skts_dp
// Datapath: key table memory, entry count, probe window and result word.
// ----------------------------------------------------------------------------
module skts_dp #(
  parameter int TABLE_DEPTH = 1024,
  parameter int KEY_CHARS   = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [skts_pkg::KEY_W-1:0]   key,
  input  logic                         search_mode,
  input  skts_pkg::skts_cmd_t          cmd,
  output skts_pkg::skts_sts_t          sts,
  output logic [skts_pkg::OUT_W-1:0]   m_tdata
);
  import skts_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} << (8 * (8 - KEY_CHARS));
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  logic [KEY_W-1:0]    mem [TABLE_DEPTH];
  logic [KEY_W-1:0]    rdata;
  logic [KEY_W-1:0]    key_q;
  logic [KEY_W-1:0]    key_m;
  logic [CW-1:0]       count;
  logic [CW-1:0]       lo;
  logic [CW-1:0]       hi;     // exclusive bound
  logic [IW-1:0]       mid;
  logic [IW-1:0]       mid_next;
  logic [CW-1:0]       lo_next;
  logic [CW-1:0]       hi_next;
  logic [STATUS_W-1:0] res_status;
  logic [INDEX_W-1:0]  res_index;

  logic          full;
  logic          eq;
  logic          gt;
  logic [CW:0]   sum_l;
  logic [CW:0]   sum_r;
  logic [CW-1:0] mid_inc;
  logic [CW-1:0] seed;

  assign key_m   = key & KEY_MASK;
  assign full    = (count >= DEPTH_C);
  assign eq      = (rdata == key_q);
  assign gt      = (key_q > rdata);
  assign mid_inc = CW'(mid) + CW'(1);
  assign sum_l   = (CW+1)'(lo) + (CW+1)'(mid) - (CW+1)'(1);
  assign sum_r   = (CW+1)'(mid) + (CW+1)'(hi);
  assign seed    = search_mode ? '0 : CW'(count - CW'(1)) >> 1;

  always_comb begin
    sts.cnt_zero = (count == '0);
    sts.hit      = eq;
    if (search_mode) begin
      sts.empty = (mid_inc >= count);
    end else if (gt) begin
      sts.empty = (mid_inc >= hi);
    end else begin
      sts.empty = (lo >= CW'(mid));
    end
  end

  // next probe address, fed straight to the memory read port
  always_comb begin
    lo_next  = lo;
    hi_next  = hi;
    mid_next = mid;
    if (cmd.accept) begin
      lo_next  = '0;
      hi_next  = count;
      mid_next = seed[IW-1:0];
    end else if (cmd.step) begin
      if (search_mode) begin
        mid_next = mid_inc[IW-1:0];
      end else if (gt) begin
        lo_next  = mid_inc;
        mid_next = sum_r[IW:1];
      end else begin
        hi_next  = CW'(mid);
        mid_next = sum_l[IW:1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op_load && !full) begin
      mem[count[IW-1:0]] <= key_m;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[mid_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.op_clear) begin
      count <= '0;
    end else if (cmd.op_load && !full) begin
      count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    lo  <= lo_next;
    hi  <= hi_next;
    mid <= mid_next;
    if (cmd.accept) begin
      key_q      <= key_m;
      res_status <= ST_OK;
      res_index  <= '0;
      if (cmd.op_load) begin
        if (full) begin
          res_status <= ST_FULL;
        end else begin
          res_index <= INDEX_W'(count);
        end
      end else if (cmd.op_search && sts.cnt_zero) begin
        res_status <= ST_MISSING;
      end
    end else if (cmd.step) begin
      if (eq) begin
        res_index <= INDEX_W'(mid);
      end else if (sts.empty) begin
        res_status <= ST_MISSING;
      end
    end
    if (cmd.out_push) begin
      m_tdata <= {(OUT_W - INDEX_W - STATUS_W)'(0), res_index, res_status};
    end
  end

endmodule

FILE: sv/sorted_key_table_search.sv
// ----------------------------------------------------------------------------
// sorted_key_table_search
// Table of packed text keys with append, clear and binary or linear search.
//
//   channel  dir  handshake          payload
//   s_*      in   tvalid/tready      tuser: kind[1:0]; tdata: key[63:0]
//   m_*      out  tvalid/tready      tdata: status[1:0], index[11:2]
//   apb      in   psel/penable/...   reg 0 @ 0x0: search_mode[0]
//
// Binary search makes one memory read per probe. Linear search probes the live
// entries in order from index 0 until a hit or the last live entry.
// Reset clears the entry count and mode; table contents are not cleared.
// The next word is taken while a result waits in the output register.
// ----------------------------------------------------------------------------
module sorted_key_table_search #(
  parameter int TABLE_DEPTH = 1024,
  parameter int KEY_CHARS   = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [skts_pkg::KEY_W-1:0]     s_tdata,   // key[63:0]
  input  logic [skts_pkg::KIND_W-1:0]    s_tuser,   // kind[1:0]
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [skts_pkg::OUT_W-1:0]     m_tdata,   // status[1:0], index[11:2]
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import skts_pkg::*;

  skts_cmd_t cmd;
  skts_sts_t sts;
  logic      search_mode;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {31'd0, search_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      search_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      search_mode <= pwdata[0];
    end
  end

  skts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .kind     (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  skts_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_CHARS   (KEY_CHARS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .key         (s_tdata),
    .search_mode (search_mode),
    .cmd         (cmd),
    .sts         (sts),
    .m_tdata     (m_tdata)
  );

endmodule
